/* rtl/core/page_bitmap_allocator_defines.svh */
// assertion macros for the page bitmap allocator
// used by files that carry concurrent assertions, expects i_clk and i_rst_n in scope
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define PBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pba assertion failed");
`define PBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pba assertion failed");
`else
`define PBA_ASSERT_IMP(lbl, ante, cons)
`define PBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/pba_pkg.sv */
// shared types and constants of the page bitmap allocator
// no dependencies
package pba_pkg;

    localparam int WORD_BITS = 32;
    localparam int ABS_W     = 24;

    localparam logic [1:0]  OP_ALLOC  = 2'd0;
    localparam logic [1:0]  OP_FREE   = 2'd1;
    localparam logic [1:0]  OP_REGION = 2'd2;
    localparam logic [31:0] REGION_USABLE = 32'd1;
    localparam logic [19:0] BASE_RESET    = 20'd4096;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REGION,
        S_CLAMP,
        S_SW_RD,
        S_SW_WR,
        S_AL_RD,
        S_AL_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       cur_free;
        logic [5:0] next_pos;
    } t_scan;

endpackage

/* rtl/core/pba_if.sv */
// valid/ready channel interfaces of the page bitmap allocator
// no dependencies
interface pba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [19:0] page;
    logic [15:0] count;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [31:0] region_type;

    modport source (output valid, op, page, count, region_base, region_length, region_type,
                    input ready);
    modport sink (input valid, op, page, count, region_base, region_length, region_type,
                  output ready);
endinterface

interface pba_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [19:0] start_page;

    modport source (output valid, ok, start_page, input ready);
    modport sink (input valid, ok, start_page, output ready);
endinterface

/* rtl/core/pba_bitmap_ram.sv */
// bitmap word memory, one write port and one registered read port
// no dependencies
module pba_bitmap_ram #(
    parameter int WORDS = 1024,
    parameter int WAW   = 10
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [WAW-1:0] i_wr_addr,
    input  logic [31:0]    i_wr_data,
    input  logic           i_rd_en,
    input  logic [WAW-1:0] i_rd_addr,
    output logic [31:0]    o_rd_data
);

    logic [31:0] r_mem [WORDS];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/pba_word_scan.sv */
// finds the end of the run of equal bits that starts at a position in a word
// depends on pba_pkg
module pba_word_scan (
    input  logic          [31:0] i_word,
    input  logic          [5:0]  i_pos,
    output pba_pkg::t_scan       o_scan
);

    logic [31:0] diff;
    logic [31:0] masked;
    logic        cur_free;
    logic [5:0]  next_pos;

    always_comb begin
        cur_free = !i_word[i_pos[4:0]];
        diff     = cur_free ? i_word : ~i_word;
        masked   = diff & (32'hffff_ffff << i_pos[4:0]);
        next_pos = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (masked[i]) begin
                next_pos = 6'(i);
            end
        end
    end

    assign o_scan.cur_free = cur_free;
    assign o_scan.next_pos = next_pos;

endmodule

/* rtl/core/page_bitmap_allocator.sv */
// first-fit page bitmap allocator: every op takes one result, one op in flight at a time
// free and region ops: one memory read-modify-write per bitmap word touched
// alloc: one memory read per bitmap word, then a scan step for each run boundary in it
// reset: a clearing pass over every bitmap word marks every page used, inputs held off
// top level, depends on pba_pkg, pba_if, pba_bitmap_ram, pba_word_scan
`include "page_bitmap_allocator_defines.svh"
module page_bitmap_allocator #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,
    pba_in_if.sink      i_in,
    pba_out_if.source   o_out
);

    localparam int WORDS  = (NUM_PAGES + 31) / 32;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int REL_W  = $clog2(NUM_PAGES + 1);
    localparam int LOG_PB = $clog2(PAGE_BYTES);
    localparam int FP_W   = 64 - LOG_PB;
    localparam int LP_W   = FP_W + 1;
    localparam int LIM_PAGES = 2 ** (32 - LOG_PB);
    localparam int ABS_W  = pba_pkg::ABS_W;
    localparam logic [WAW-1:0] LAST_W = WAW'(WORDS - 1);

    pba_pkg::t_state r_state, n_state;
    logic [WAW-1:0]   r_w, n_w;
    logic [5:0]       r_pos, n_pos;
    logic [16:0]      r_run, n_run;
    logic [REL_W-1:0] r_run_start, n_run_start;
    logic [15:0]      r_count, n_count;
    logic [REL_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic             r_set, n_set;
    logic [ABS_W-1:0] r_abs_lo, n_abs_lo, r_abs_hi, n_abs_hi;
    logic [FP_W-1:0]  r_first, n_first, r_alen_pg, n_alen_pg;
    logic             r_ovf, n_ovf;
    logic [19:0]      r_base;
    logic             r_res_ok, n_res_ok;
    logic [19:0]      r_res_start, n_res_start;
    logic             r_out_valid, n_out_valid, r_out_ok, n_out_ok;
    logic [19:0]      r_out_start, n_out_start;

    logic           wr_en, rd_en;
    logic [WAW-1:0] wr_addr, rd_addr;
    logic [31:0]    wr_data, rd_data;
    pba_pkg::t_scan scn;

    logic             accept, out_free;
    logic [5:0]       seg_len;
    logic [16:0]      run_sum;
    logic [REL_W-1:0] cur_idx, eff_start;
    logic             al_found, word_end, last_word;
    logic [REL_W-1:0] hm1;
    logic [WAW-1:0]   lo_w, hi_w;
    logic [4:0]       lo_b, hi_b;
    logic [31:0]      mask;
    logic [ABS_W-1:0] whi, clo, chi;
    logic             clamp_ok;
    logic [LOG_PB-1:0] rem;
    logic [64:0]      rsum;
    logic [FP_W-1:0]  alen_raw;
    logic [LP_W-1:0]  rg_last, rg_lo, rg_hi, base_p1;
    logic             region_ok;

    pba_bitmap_ram #(.WORDS(WORDS), .WAW(WAW)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pba_word_scan u_scan (
        .i_word (rd_data),
        .i_pos  (r_pos),
        .o_scan (scn)
    );

    assign i_in.ready       = (r_state == pba_pkg::S_IDLE);
    assign accept           = i_in.valid && i_in.ready;
    assign out_free         = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.ok         = r_out_ok;
    assign o_out.start_page = r_out_start;

    // alloc run tracking
    assign seg_len   = scn.next_pos - r_pos;
    assign run_sum   = r_run + 17'(seg_len);
    assign cur_idx   = REL_W'({r_w, r_pos[4:0]});
    assign eff_start = (r_run == 17'd0) ? cur_idx : r_run_start;
    assign al_found  = scn.cur_free && (run_sum >= 17'(r_count));
    assign word_end  = scn.next_pos[5];
    assign last_word = (r_w == LAST_W);

    // sweep mask
    assign hm1  = r_hi - REL_W'(1);
    assign lo_w = WAW'(r_lo >> 5);
    assign hi_w = WAW'(hm1 >> 5);
    assign lo_b = (r_w == lo_w) ? r_lo[4:0] : 5'd0;
    assign hi_b = (r_w == hi_w) ? hm1[4:0] : 5'd31;
    assign mask = (32'hffff_ffff << lo_b) & (32'hffff_ffff >> (5'd31 - hi_b));

    // window clamp
    assign whi      = ABS_W'(r_base) + ABS_W'(NUM_PAGES);
    assign clo      = (r_abs_lo < ABS_W'(r_base)) ? ABS_W'(r_base) : r_abs_lo;
    assign chi      = (r_abs_hi > whi) ? whi : r_abs_hi;
    assign clamp_ok = (clo < chi);

    // region alignment
    assign rem      = i_in.region_base[LOG_PB-1:0];
    assign rsum     = {1'b0, i_in.region_base} + (65'(PAGE_BYTES) - 65'(rem));
    assign alen_raw = i_in.region_length[63:LOG_PB];
    assign rg_last  = LP_W'(r_first) + LP_W'(r_alen_pg);
    assign base_p1  = LP_W'(r_base) + LP_W'(1);
    assign rg_lo    = (LP_W'(r_first) < base_p1) ? base_p1 : LP_W'(r_first);
    assign rg_hi    = (rg_last > LP_W'(LIM_PAGES)) ? LP_W'(LIM_PAGES) : rg_last;
    assign region_ok = !r_ovf && (rg_lo < rg_hi);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pba_pkg::S_CLEAR: begin
                if (last_word) n_state = pba_pkg::S_IDLE;
            end
            pba_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_in.op)
                        pba_pkg::OP_ALLOC: begin
                            n_state = (i_in.count == 16'd0) ? pba_pkg::S_DONE
                                                            : pba_pkg::S_AL_RD;
                        end
                        pba_pkg::OP_FREE: n_state = pba_pkg::S_CLAMP;
                        pba_pkg::OP_REGION: begin
                            n_state = (i_in.region_type == pba_pkg::REGION_USABLE)
                                      ? pba_pkg::S_REGION : pba_pkg::S_DONE;
                        end
                        default: n_state = pba_pkg::S_DONE;
                    endcase
                end
            end
            pba_pkg::S_REGION: n_state = region_ok ? pba_pkg::S_CLAMP : pba_pkg::S_DONE;
            pba_pkg::S_CLAMP:  n_state = clamp_ok ? pba_pkg::S_SW_RD : pba_pkg::S_DONE;
            pba_pkg::S_SW_RD:  n_state = pba_pkg::S_SW_WR;
            pba_pkg::S_SW_WR: begin
                n_state = (r_w == hi_w) ? pba_pkg::S_DONE : pba_pkg::S_SW_RD;
            end
            pba_pkg::S_AL_RD: n_state = pba_pkg::S_AL_SCAN;
            pba_pkg::S_AL_SCAN: begin
                if (al_found) begin
                    n_state = pba_pkg::S_SW_RD;
                end else if (word_end) begin
                    n_state = last_word ? pba_pkg::S_DONE : pba_pkg::S_AL_RD;
                end
            end
            pba_pkg::S_DONE: begin
                if (out_free) n_state = pba_pkg::S_IDLE;
            end
            default: n_state = pba_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_w         = r_w;
        n_pos       = r_pos;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_abs_lo    = r_abs_lo;
        n_abs_hi    = r_abs_hi;
        n_first     = r_first;
        n_alen_pg   = r_alen_pg;
        n_ovf       = r_ovf;
        n_res_ok    = r_res_ok;
        n_res_start = r_res_start;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_ok    = r_out_ok;
        n_out_start = r_out_start;
        wr_en       = 1'b0;
        wr_addr     = r_w;
        wr_data     = r_set ? (rd_data | mask) : (rd_data & ~mask);
        rd_en       = 1'b0;
        rd_addr     = r_w;
        unique case (r_state)
            pba_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = 32'hffff_ffff;
                n_w     = r_w + WAW'(1);
            end
            pba_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_ok    = 1'b0;
                    n_res_start = 20'd0;
                    n_count     = i_in.count;
                    n_w         = '0;
                    n_pos       = 6'd0;
                    n_run       = 17'd0;
                    n_set       = 1'b0;
                    n_abs_lo    = ABS_W'(i_in.page);
                    n_abs_hi    = ABS_W'(i_in.page) + ABS_W'(i_in.count);
                    if (rem != '0) begin
                        n_first   = rsum[63:LOG_PB];
                        n_ovf     = rsum[64];
                        n_alen_pg = alen_raw - FP_W'(alen_raw != '0);
                    end else begin
                        n_first   = i_in.region_base[63:LOG_PB];
                        n_ovf     = 1'b0;
                        n_alen_pg = alen_raw;
                    end
                    if (i_in.op == pba_pkg::OP_FREE) n_res_ok = 1'b1;
                    if (i_in.op == pba_pkg::OP_REGION &&
                        i_in.region_type == pba_pkg::REGION_USABLE) n_res_ok = 1'b1;
                end
            end
            pba_pkg::S_REGION: begin
                n_abs_lo = ABS_W'(rg_lo);
                n_abs_hi = ABS_W'(rg_hi);
            end
            pba_pkg::S_CLAMP: begin
                n_lo = REL_W'(clo - ABS_W'(r_base));
                n_hi = REL_W'(chi - ABS_W'(r_base));
                n_w  = WAW'(REL_W'(clo - ABS_W'(r_base)) >> 5);
            end
            pba_pkg::S_SW_RD: begin
                rd_en = 1'b1;
            end
            pba_pkg::S_SW_WR: begin
                wr_en = 1'b1;
                n_w   = r_w + WAW'(1);
            end
            pba_pkg::S_AL_RD: begin
                rd_en = 1'b1;
            end
            pba_pkg::S_AL_SCAN: begin
                if (al_found) begin
                    n_res_ok    = 1'b1;
                    n_res_start = r_base + 20'(eff_start);
                    n_lo        = eff_start;
                    n_hi        = eff_start + REL_W'(r_count);
                    n_w         = WAW'(eff_start >> 5);
                    n_set       = 1'b1;
                end else begin
                    if (scn.cur_free) begin
                        n_run = run_sum;
                        if (r_run == 17'd0) n_run_start = cur_idx;
                    end else begin
                        n_run = 17'd0;
                    end
                    n_pos = scn.next_pos;
                    if (word_end && !last_word) begin
                        n_w   = r_w + WAW'(1);
                        n_pos = 6'd0;
                    end
                end
            end
            pba_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_start = r_res_start;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pba_pkg::S_CLEAR;
            r_w         <= '0;
            r_out_valid <= 1'b0;
            r_base      <= pba_pkg::BASE_RESET;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_run       <= n_run;
        r_run_start <= n_run_start;
        r_count     <= n_count;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_set       <= n_set;
        r_abs_lo    <= n_abs_lo;
        r_abs_hi    <= n_abs_hi;
        r_first     <= n_first;
        r_alen_pg   <= n_alen_pg;
        r_ovf       <= n_ovf;
        r_res_ok    <= n_res_ok;
        r_res_start <= n_res_start;
        r_out_ok    <= n_out_ok;
        r_out_start <= n_out_start;
    end

    `PBA_ASSERT_IMP(a_rose_after_done, $rose(r_out_valid), $past(r_state) == pba_pkg::S_DONE)
    `PBA_ASSERT_IMP(a_no_write_idle, wr_en, r_state != pba_pkg::S_IDLE)
    `PBA_ASSERT_IMP(a_fail_zero_start, r_out_valid && !r_out_ok, r_out_start == 20'd0)
    `PBA_ASSERT_NXT(a_accept_leaves_idle, accept, r_state != pba_pkg::S_IDLE)

endmodule
